@@ design/rob_pkg.sv @@
package rob_pkg;

  localparam int unsigned DepthDef = 64;

  // Result status codes
  localparam logic [2:0] StStored = 3'd0;
  localparam logic [2:0] StEvict  = 3'd1;
  localparam logic [2:0] StPass   = 3'd2;
  localparam logic [2:0] StDup    = 3'd3;
  localparam logic [2:0] StFlush  = 3'd4;

  localparam logic CmdPush  = 1'b0;
  localparam logic CmdFlush = 1'b1;

  typedef struct packed {
    logic [31:0] seconds;
    logic [19:0] fraction;
    logic [15:0] length;
    logic [31:0] handle;
  } entry_t;

  // Source of the packet fields of a result item
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_HEAD,
    SEL_ITEM,
    SEL_RDATA
  } out_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic       item_ld;
    logic       head_ld;
    logic       we;
    logic       wsel_item;
    logic       out_ld;
    out_sel_e   out_sel;
    logic [2:0] out_status;
    logic       out_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic key_lt;
    logic key_eq;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/rob_if.sv @@
interface rob_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] ts_seconds;
  logic [19:0] ts_fraction;
  logic [15:0] pkt_len;
  logic [31:0] pkt_handle;

  modport source (output valid, cmd, ts_seconds, ts_fraction, pkt_len, pkt_handle,
                  input ready);
  modport sink (input valid, cmd, ts_seconds, ts_fraction, pkt_len, pkt_handle,
                output ready);
endinterface

interface rob_out_if;
  logic        valid;
  logic        ready;
  logic        emit_valid;
  logic [31:0] out_handle;
  logic [15:0] out_len;
  logic [31:0] out_seconds;
  logic [19:0] out_fraction;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, emit_valid, out_handle, out_len, out_seconds,
                  out_fraction, status, last, input ready);
  modport sink (input valid, emit_valid, out_handle, out_len, out_seconds,
                out_fraction, status, last, output ready);
endinterface

@@ design/rob_datapath.sv @@
module rob_datapath import rob_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dp_cmd_t       cmd_i,
  input  logic [AW-1:0] raddr_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        in_entry_i,
  output dp_stat_t      stat_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic          emit_valid_o,
  output entry_t        out_entry_o,
  output logic [2:0]    status_o,
  output logic          last_o
);

  entry_t     mem_q [DEPTH];
  entry_t     rdata_q;
  entry_t     item_q;
  entry_t     head_q;
  entry_t     wdata;
  entry_t     sel_entry;
  logic [51:0] rkey, ikey;

  // Entry store, one write and one registered read per cycle
  assign wdata = cmd_i.wsel_item ? item_q : rdata_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) mem_q[waddr_i] <= wdata;
    rdata_q <= mem_q[raddr_i];
  end

  // Held item and oldest entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_ld) item_q <= in_entry_i;
    if (cmd_i.head_ld) head_q <= rdata_q;
  end

  // Timestamp compare
  assign rkey = {rdata_q.seconds, rdata_q.fraction};
  assign ikey = {item_q.seconds, item_q.fraction};
  assign stat_o.key_lt   = rkey < ikey;
  assign stat_o.key_eq   = rkey == ikey;
  assign stat_o.out_free = !out_valid_o || out_ready_i;

  always_comb begin
    case (cmd_i.out_sel)
      SEL_HEAD:  sel_entry = head_q;
      SEL_ITEM:  sel_entry = item_q;
      SEL_RDATA: sel_entry = rdata_q;
      default:   sel_entry = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_entry_o  <= sel_entry;
      emit_valid_o <= cmd_i.out_sel != SEL_NONE;
      status_o     <= cmd_i.out_status;
      last_o       <= cmd_i.out_last;
    end
  end

endmodule

@@ design/rob_ctrl.sv @@
module rob_ctrl import rob_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = AW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_cmd_i,
  output logic          in_ready_o,
  input  dp_stat_t      stat_i,
  output dp_cmd_t       cmd_o,
  output logic [AW-1:0] raddr_o,
  output logic [AW-1:0] waddr_o
);

  typedef enum logic [3:0] {
    IDLE, S_RD, S_CMP, DEC, SD_RD, SD_WR, SU_RD, SU_WR, INS, RES, F_RD, F_OUT
  } state_e;

  state_e        st_q, st_d;
  logic [CW-1:0] idx_q, idx_d, pos_q, pos_d, occ_q, occ_d;
  logic [2:0]    res_q, res_d;
  logic [CW-1:0] idx_p1, idx_m1, pos_m1;
  logic          full;

  assign idx_p1 = idx_q + CW'(1);
  assign idx_m1 = idx_q - CW'(1);
  assign pos_m1 = pos_q - CW'(1);
  assign full   = occ_q == CW'(DEPTH);

  always_comb begin
    st_d       = st_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    occ_d      = occ_q;
    res_d      = res_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    raddr_o    = idx_q[AW-1:0];
    waddr_o    = idx_q[AW-1:0];
    unique case (st_q)
      IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_ld = 1'b1;
          idx_d = '0;
          pos_d = '0;
          if (in_cmd_i == CmdFlush) begin
            res_d = StFlush;
            st_d  = (occ_q == '0) ? RES : F_RD;
          end else begin
            st_d = (occ_q == '0) ? DEC : S_RD;
          end
        end
      end
      // Linear search for the insert point
      S_RD: st_d = S_CMP;
      S_CMP: begin
        if (idx_q == '0) cmd_o.head_ld = 1'b1;
        if (stat_i.key_lt) begin
          idx_d = idx_p1;
          if (idx_p1 == occ_q) begin
            pos_d = occ_q;
            st_d  = DEC;
          end else begin
            st_d = S_RD;
          end
        end else if (stat_i.key_eq) begin
          res_d = StDup;
          st_d  = RES;
        end else begin
          pos_d = idx_q;
          st_d  = DEC;
        end
      end
      DEC: begin
        if (full) begin
          if (pos_q == '0) begin
            res_d = StPass;
            st_d  = RES;
          end else begin
            idx_d = CW'(1);
            st_d  = (pos_q == CW'(1)) ? INS : SD_RD;
          end
        end else begin
          idx_d = occ_q;
          st_d  = (occ_q == pos_q) ? INS : SU_RD;
        end
      end
      // Shift entries toward the head (full store)
      SD_RD: st_d = SD_WR;
      SD_WR: begin
        cmd_o.we = 1'b1;
        waddr_o  = idx_m1[AW-1:0];
        idx_d    = idx_p1;
        st_d     = (idx_p1 == pos_q) ? INS : SD_RD;
      end
      // Shift entries toward the tail
      SU_RD: begin
        raddr_o = idx_m1[AW-1:0];
        st_d    = SU_WR;
      end
      SU_WR: begin
        raddr_o  = idx_m1[AW-1:0];
        cmd_o.we = 1'b1;
        idx_d    = idx_m1;
        st_d     = (idx_m1 == pos_q) ? INS : SU_RD;
      end
      INS: begin
        if (stat_i.out_free) begin
          cmd_o.we         = 1'b1;
          cmd_o.wsel_item  = 1'b1;
          waddr_o          = full ? pos_m1[AW-1:0] : pos_q[AW-1:0];
          cmd_o.out_ld     = 1'b1;
          cmd_o.out_sel    = full ? SEL_HEAD : SEL_NONE;
          cmd_o.out_status = full ? StEvict : StStored;
          cmd_o.out_last   = 1'b1;
          if (!full) occ_d = occ_q + CW'(1);
          st_d = IDLE;
        end
      end
      RES: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld     = 1'b1;
          cmd_o.out_sel    = (res_q == StPass) ? SEL_ITEM : SEL_NONE;
          cmd_o.out_status = res_q;
          cmd_o.out_last   = 1'b1;
          st_d = IDLE;
        end
      end
      // Flush: read each entry and emit it
      F_RD: st_d = F_OUT;
      F_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld     = 1'b1;
          cmd_o.out_sel    = SEL_RDATA;
          cmd_o.out_status = StFlush;
          cmd_o.out_last   = idx_p1 == occ_q;
          if (idx_p1 == occ_q) begin
            occ_d = '0;
            st_d  = IDLE;
          end else begin
            idx_d = idx_p1;
            st_d  = F_RD;
          end
        end
      end
      default: st_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= IDLE;
      idx_q <= '0;
      pos_q <= '0;
      occ_q <= '0;
      res_q <= StStored;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      pos_q <= pos_d;
      occ_q <= occ_d;
      res_q <= res_d;
    end
  end

endmodule

@@ design/timestamp_reorder_buffer.sv @@
// Sorted store of up to DEPTH packets, searched and shifted one entry at a time.
// A push compares stored entries in order, moves entries as needed, stores or
// rejects the item and loads its result. One item in flight; the next is taken in
// the cycle after the result is loaded. A flush reads and emits each stored entry.
// Output stalls hold any result. The one-read, one-write entry memory sets the rate.
// Reset clears the occupancy and control; entry contents are not cleared.
module timestamp_reorder_buffer import rob_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input logic clk_i,
  input logic rst_ni,
  rob_in_if.sink    in_i,
  rob_out_if.source out_o
);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] raddr, waddr;
  entry_t        in_entry, out_entry;

  assign in_entry = '{seconds: in_i.ts_seconds, fraction: in_i.ts_fraction,
                      length: in_i.pkt_len, handle: in_i.pkt_handle};

  rob_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .raddr_o    (raddr),
    .waddr_o    (waddr)
  );

  rob_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .raddr_i      (raddr),
    .waddr_i      (waddr),
    .in_entry_i   (in_entry),
    .stat_o       (stat),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .emit_valid_o (out_o.emit_valid),
    .out_entry_o  (out_entry),
    .status_o     (out_o.status),
    .last_o       (out_o.last)
  );

  assign out_o.out_handle   = out_entry.handle;
  assign out_o.out_len      = out_entry.length;
  assign out_o.out_seconds  = out_entry.seconds;
  assign out_o.out_fraction = out_entry.fraction;

`ifndef ASSERT_OFF
  // One item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("accepted item while busy");

  // Duplicate or stored results carry no packet
  a_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == StDup || out_o.status == StStored)
      |-> !out_o.emit_valid)
    else $error("packet emitted on non-emitting result");

  // Push results are always single and final
  a_push_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != StFlush |-> out_o.last)
    else $error("push result not marked last");
`endif

endmodule
